// ===== design/mwr_pkg.sv =====
package mwr_pkg;

  localparam int FIELD_COUNT_DEF = 9;
  localparam int FIELD_WIDTH_DEF = 7;
  localparam int PACKED_W        = 63;
  localparam int TARGET_W        = 7;
  localparam int MASK_W          = 9;

  typedef struct packed {
    logic [PACKED_W-1:0] packed_weights;
    logic [TARGET_W-1:0] target_total;
    logic [MASK_W-1:0]   enable_mask;
  } request_t;

  typedef struct packed {
    logic [PACKED_W-1:0] adjusted_weights;
    logic                unreachable;
  } result_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // sequencer to datapath
  typedef struct packed {
    logic load;    // capture a new transaction
    logic active;  // current field may be stepped this cycle
    logic dec;     // step direction: 1 lowers, 0 raises
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic at_target;
    logic above;
    logic step;
  } stat_t;

  // sequencer to output stage
  typedef struct packed {
    logic finish;
    logic stuck;
  } fin_t;

endpackage

// ===== design/mwr_step_unit.sv =====
module mwr_step_unit #(
  parameter int FIELD_WIDTH = mwr_pkg::FIELD_WIDTH_DEF,
  parameter int SUM_W       = 11
) (
  input  logic [FIELD_WIDTH-1:0] value,
  input  logic [SUM_W-1:0]       total,
  input  logic [SUM_W-1:0]       target,
  input  logic                   dec,
  output logic                   step,
  output logic [FIELD_WIDTH-1:0] value_next,
  output logic [SUM_W-1:0]       total_next
);

  localparam logic [FIELD_WIDTH-1:0] FIELD_MAX = {FIELD_WIDTH{1'b1}};

  logic [SUM_W-1:0] value_ext;
  logic             can_dec;
  logic             can_inc;

  assign value_ext = SUM_W'(value);
  assign can_dec   = (value > FIELD_WIDTH'(1)) && (total > target);
  // zero fields stay zero; never raise past the field ceiling
  assign can_inc   = (value != '0) && (value_ext < target) && (value != FIELD_MAX)
                     && (total < target);
  assign step      = dec ? can_dec : can_inc;

  assign value_next = dec ? value - FIELD_WIDTH'(1) : value + FIELD_WIDTH'(1);
  assign total_next = dec ? total - SUM_W'(1) : total + SUM_W'(1);

endmodule

// ===== design/mwr_datapath.sv =====
module mwr_datapath #(
  parameter int FIELD_COUNT = mwr_pkg::FIELD_COUNT_DEF,
  parameter int FIELD_WIDTH = mwr_pkg::FIELD_WIDTH_DEF,
  parameter int IDX_W       = 4,
  parameter int SUM_W       = 11
) (
  input  logic                          clk,
  input  mwr_pkg::ctrl_t                ctrl,
  input  logic [IDX_W-1:0]              idx,
  input  mwr_pkg::request_t             request,
  output mwr_pkg::stat_t                stat,
  output logic [mwr_pkg::PACKED_W-1:0]  adjusted_word,
  output logic [mwr_pkg::PACKED_W-1:0]  masked_word
);

  logic [FIELD_WIDTH-1:0] weight [FIELD_COUNT];
  logic [FIELD_WIDTH-1:0] masked [FIELD_COUNT];
  logic [FIELD_WIDTH-1:0] in_field [FIELD_COUNT];
  logic [SUM_W-1:0]       total;
  logic [SUM_W-1:0]       target;
  logic [SUM_W-1:0]       in_sum;
  logic                   step_ok;
  logic [FIELD_WIDTH-1:0] value_next;
  logic [SUM_W-1:0]       total_next;

  always_comb begin
    in_sum = '0;
    for (int i = 0; i < FIELD_COUNT; i++) begin
      in_field[i] = request.enable_mask[i] ?
                    request.packed_weights[FIELD_WIDTH*i +: FIELD_WIDTH] : '0;
      in_sum = in_sum + SUM_W'(in_field[i]);
    end
  end

  mwr_step_unit #(
    .FIELD_WIDTH (FIELD_WIDTH),
    .SUM_W       (SUM_W)
  ) u_step (
    .value      (weight[idx]),
    .total      (total),
    .target     (target),
    .dec        (ctrl.dec),
    .step       (step_ok),
    .value_next (value_next),
    .total_next (total_next)
  );

  assign stat.at_target = (total == target);
  assign stat.above     = (total > target);
  assign stat.step      = ctrl.active && step_ok;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < FIELD_COUNT; i++) begin
        weight[i] <= in_field[i];
        masked[i] <= in_field[i];
      end
      total  <= in_sum;
      target <= SUM_W'(request.target_total);
    end else if (stat.step) begin
      weight[idx] <= value_next;
      total       <= total_next;
    end
  end

  always_comb begin
    adjusted_word = '0;
    masked_word   = '0;
    for (int i = 0; i < FIELD_COUNT; i++) begin
      adjusted_word[FIELD_WIDTH*i +: FIELD_WIDTH] = weight[i];
      masked_word[FIELD_WIDTH*i +: FIELD_WIDTH]   = masked[i];
    end
  end

endmodule

// ===== design/mwr_seq.sv =====
module mwr_seq #(
  parameter int FIELD_COUNT = mwr_pkg::FIELD_COUNT_DEF,
  parameter int IDX_W       = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mwr_pkg::stat_t   stat,
  output mwr_pkg::ctrl_t   ctrl,
  output mwr_pkg::fin_t    fin,
  output logic [IDX_W-1:0] idx,
  output logic             busy
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIELD_COUNT - 1);

  mwr_pkg::state_t state;
  mwr_pkg::state_t state_next;

  logic first;    // cycle opens a pass
  logic dir;      // direction chosen at pass start
  logic changed;  // some field stepped in this pass
  logic dir_eff;
  logic changed_eff;
  logic finish_ok;
  logic finish_stuck;
  logic last;

  assign dir_eff      = first ? stat.above : dir;
  assign last         = (idx == LAST_IDX);
  assign finish_ok    = first && stat.at_target;
  assign changed_eff  = (!first && changed) || stat.step;
  assign finish_stuck = !finish_ok && last && !changed_eff;

  always_comb begin
    state_next = state;
    unique case (state)
      mwr_pkg::S_IDLE: begin
        if (start) state_next = mwr_pkg::S_SCAN;
      end
      mwr_pkg::S_SCAN: begin
        if (finish_ok || finish_stuck) state_next = mwr_pkg::S_IDLE;
      end
      default: state_next = mwr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.load   = 1'b0;
    ctrl.active = 1'b0;
    ctrl.dec    = dir_eff;
    fin.finish  = 1'b0;
    fin.stuck   = 1'b0;
    busy        = 1'b0;
    unique case (state)
      mwr_pkg::S_IDLE: begin
        ctrl.load = start;
      end
      mwr_pkg::S_SCAN: begin
        busy        = 1'b1;
        ctrl.active = !finish_ok;
        fin.finish  = finish_ok || finish_stuck;
        fin.stuck   = finish_stuck;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mwr_pkg::S_IDLE;
      idx     <= '0;
      first   <= 1'b1;
      dir     <= 1'b0;
      changed <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.load) begin
        idx     <= '0;
        first   <= 1'b1;
        changed <= 1'b0;
      end else if (ctrl.active) begin
        if (last) begin
          // wrap to the next pass
          idx   <= '0;
          first <= 1'b1;
        end else begin
          idx     <= idx + IDX_W'(1);
          first   <= 1'b0;
          dir     <= dir_eff;
          changed <= changed_eff;
        end
      end
    end
  end

endmodule

// ===== design/masked_weight_renormalize.sv =====
// masked_weight_renormalize
//
// Command port: drive request and raise start; the transaction is taken at a
// rising edge with start high and busy low. busy stays high while the fields
// are being adjusted, and no new transaction is taken then.
// Result port: done is high for exactly one cycle with result valid in that
// cycle. The receiver cannot stall the block, so a result must be taken then.
// Operation: the adjustment walks one field per cycle through a single
// compare/step unit in round-robin passes over the fields. The block
// finishes when a pass opens with the masked sum equal to the target and
// returns the adjusted fields; done is registered from that finishing
// cycle. The default is nine 7-bit fields. One transaction is in flight at
// a time; the next one may be issued in the cycle that done is high.
// Unreachable targets end at the close of the first pass that steps no
// field; the masked input fields are then returned with unreachable set.
// Reset: synchronous, active high; clears the sequencer and done, leaving the
// block idle and ready. No state carries from one transaction to the next.
module masked_weight_renormalize #(
  parameter int FIELD_COUNT = mwr_pkg::FIELD_COUNT_DEF,
  parameter int FIELD_WIDTH = mwr_pkg::FIELD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mwr_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output mwr_pkg::result_t  result
);

  localparam int IDX_W   = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1;
  localparam int MAX_SUM = FIELD_COUNT * ((1 << FIELD_WIDTH) - 1);
  localparam int RAW_W   = $clog2(MAX_SUM + 1);
  localparam int SUM_W   = (RAW_W > mwr_pkg::TARGET_W) ? RAW_W : mwr_pkg::TARGET_W;

  mwr_pkg::ctrl_t ctrl;
  mwr_pkg::stat_t stat;
  mwr_pkg::fin_t  fin;

  logic [IDX_W-1:0]             idx;
  logic [mwr_pkg::PACKED_W-1:0] adjusted_word;
  logic [mwr_pkg::PACKED_W-1:0] masked_word;

  mwr_seq #(
    .FIELD_COUNT (FIELD_COUNT),
    .IDX_W       (IDX_W)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .fin   (fin),
    .idx   (idx),
    .busy  (busy)
  );

  mwr_datapath #(
    .FIELD_COUNT (FIELD_COUNT),
    .FIELD_WIDTH (FIELD_WIDTH),
    .IDX_W       (IDX_W),
    .SUM_W       (SUM_W)
  ) u_dp (
    .clk           (clk),
    .ctrl          (ctrl),
    .idx           (idx),
    .request       (request),
    .stat          (stat),
    .adjusted_word (adjusted_word),
    .masked_word   (masked_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.finish;
    end
  end

  // hold the result register between transactions
  always_ff @(posedge clk) begin
    if (fin.finish) begin
      result.adjusted_weights <= fin.stuck ? masked_word : adjusted_word;
      result.unreachable      <= fin.stuck;
    end
  end

endmodule

// ===== design/mwr_checker.sv =====
module mwr_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input mwr_pkg::result_t result
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("block not idle after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a transaction in flight");

  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("block still busy while presenting a result");

endmodule

bind masked_weight_renormalize mwr_checker u_mwr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
